// ===== hw/rtl/sws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

  // storage geometry
  localparam int DEPTH      = 256;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  // transaction field widths
  localparam int OPCODE_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 8;
  localparam int DATA_W     = 32;
  localparam int POSITION_W = 8;
  localparam int COUNT_W    = 9;
  localparam int STATUS_W   = 2;

  // common width for comparing a requested index against the fill count
  localparam int IDX_CMP_BITS = (COUNT_BITS > INDEX_W) ? COUNT_BITS : INDEX_W;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_FINISH
  } state_t;

  // one access cycle of the entry memory
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [DATA_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

  // one finished result
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [POSITION_W-1:0]    position;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sws_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sws_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sws_ctrl (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [sws_pkg::OPCODE_W-1:0]          opcode,
  input  wire logic signed [sws_pkg::VALUE_W-1:0]    value,
  input  wire logic [sws_pkg::INDEX_W-1:0]           index,
  output sws_pkg::mem_req_t                          mem_req,
  input  wire logic [sws_pkg::DATA_BITS-1:0]         rdata,
  output logic                                       res_valid,
  input  wire logic                                  res_ready,
  output sws_pkg::res_t                              res
);

  sws_pkg::state_t state, state_next;

  logic [sws_pkg::COUNT_BITS-1:0] fill;
  logic [sws_pkg::COUNT_BITS-1:0] fill_dec;
  logic [sws_pkg::DATA_BITS-1:0]  key;
  logic [sws_pkg::ADDR_BITS-1:0]  scan_idx;
  logic [sws_pkg::ADDR_BITS-1:0]  scan_inc;
  logic signed [sws_pkg::DATA_W-1:0]    res_data;
  logic [sws_pkg::POSITION_W-1:0] res_pos;
  logic [sws_pkg::STATUS_W-1:0]   res_status;

  logic accept;
  logic full;
  logic empty;
  logic idx_hit;
  logic scan_last;
  logic match;

  assign accept    = in_valid && in_ready;
  assign full      = (fill == sws_pkg::COUNT_BITS'(sws_pkg::DEPTH));
  assign empty     = (fill == '0);
  assign fill_dec  = fill - sws_pkg::COUNT_BITS'(1);
  assign idx_hit   = (sws_pkg::IDX_CMP_BITS'(index) < sws_pkg::IDX_CMP_BITS'(fill));
  assign scan_inc  = scan_idx + sws_pkg::ADDR_BITS'(1);
  assign scan_last = ((sws_pkg::COUNT_BITS'(scan_idx) + sws_pkg::COUNT_BITS'(1)) == fill);
  assign match     = (rdata == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sws_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = fill[sws_pkg::ADDR_BITS-1:0];
    mem_req.wdata = sws_pkg::DATA_BITS'(value);
    mem_req.re    = 1'b0;
    mem_req.raddr = '0;
    case (state)
      sws_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = sws_pkg::S_FINISH;
          case (opcode)
            sws_pkg::OP_PUSH: begin
              mem_req.we = !full;
            end
            sws_pkg::OP_POP: begin
              if (!empty) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = fill_dec[sws_pkg::ADDR_BITS-1:0];
                state_next    = sws_pkg::S_FETCH;
              end
            end
            sws_pkg::OP_READ: begin
              if (idx_hit) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = sws_pkg::ADDR_BITS'(index);
                state_next    = sws_pkg::S_FETCH;
              end
            end
            default: begin
              if (!empty) begin
                mem_req.re = 1'b1;
                state_next = sws_pkg::S_SCAN;
              end
            end
          endcase
        end
      end
      sws_pkg::S_FETCH: begin
        state_next = sws_pkg::S_FINISH;
      end
      sws_pkg::S_SCAN: begin
        if (match || scan_last) begin
          state_next = sws_pkg::S_FINISH;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = scan_inc;
        end
      end
      sws_pkg::S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = sws_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sws_pkg::S_IDLE;
      end
    endcase
  end

  // fill count moves at acceptance, in the same cycle as the memory write or read request
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      if (opcode == sws_pkg::OP_PUSH && !full) begin
        fill <= fill + sws_pkg::COUNT_BITS'(1);
      end else if (opcode == sws_pkg::OP_POP && !empty) begin
        fill <= fill_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= sws_pkg::DATA_BITS'(value);
      res_data <= '0;
      res_pos  <= '0;
      scan_idx <= '0;
      case (opcode)
        sws_pkg::OP_PUSH:   res_status <= full ? sws_pkg::STAT_FULL : sws_pkg::STAT_OK;
        sws_pkg::OP_POP:    res_status <= empty ? sws_pkg::STAT_EMPTY : sws_pkg::STAT_OK;
        sws_pkg::OP_READ:   res_status <= idx_hit ? sws_pkg::STAT_OK : sws_pkg::STAT_MISS;
        default:            res_status <= sws_pkg::STAT_MISS;
      endcase
    end else if (state == sws_pkg::S_FETCH) begin
      res_data <= sws_pkg::DATA_W'($signed(rdata));
    end else if (state == sws_pkg::S_SCAN) begin
      scan_idx <= scan_inc;
      if (match) begin
        res_status <= sws_pkg::STAT_OK;
        res_pos    <= sws_pkg::POSITION_W'(scan_idx);
      end
    end
  end

  assign res.data     = res_data;
  assign res.position = res_pos;
  assign res.count    = sws_pkg::COUNT_W'(fill);
  assign res.status   = res_status;

endmodule

`default_nettype wire

// ===== hw/rtl/stack_with_search.sv =====
// sequence: push or refused operation idle then finish, pop or read idle, fetch, finish, search
//   idle, scan for each of the n entries compared (1 up to the fill count, at most 256), finish
// flow: one transaction at a time; a new one is taken only once the previous result has left
//   the sequencer, and a search walks the entry memory through its single read port
// reset: synchronous, active high; empties the stack and drops any pending result,
//   entry contents are left as they are and only held entries are ever read
`timescale 1ns / 1ps
`default_nettype none

module stack_with_search (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [sws_pkg::OPCODE_W-1:0]         opcode,
  input  wire logic signed [sws_pkg::VALUE_W-1:0]   value,
  input  wire logic [sws_pkg::INDEX_W-1:0]          index,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [sws_pkg::DATA_W-1:0]         data,
  output logic [sws_pkg::POSITION_W-1:0]            position,
  output logic [sws_pkg::COUNT_W-1:0]               count,
  output logic [sws_pkg::STATUS_W-1:0]              status
);

  sws_pkg::mem_req_t              mem_req;
  logic [sws_pkg::DATA_BITS-1:0]  rdata;
  sws_pkg::res_t                  res;
  logic                           res_valid;
  logic                           res_ready;

  // sequencer: decodes the transaction, keeps the fill count and walks the memory
  sws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .index     (index),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // entry store, one write and one registered read per cycle
  sws_ram #(
    .WIDTH (sws_pkg::DATA_BITS),
    .DEPTH (sws_pkg::DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // output register: the result sits here while the sequencer returns to idle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data     <= res.data;
      position <= res.position;
      count    <= res.count;
      status   <= res.status;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sws_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [sws_pkg::DATA_W-1:0]  data,
  input wire logic [sws_pkg::POSITION_W-1:0]     position,
  input wire logic [sws_pkg::COUNT_W-1:0]        count,
  input wire logic [sws_pkg::STATUS_W-1:0]       status
);

  // one transaction at a time: the input closes right after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after an accepted transaction");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(position)
      && $stable(count) && $stable(status))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count <= sws_pkg::COUNT_W'(sws_pkg::DEPTH))
    else $error("count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sws_pkg::STAT_FULL |-> count == sws_pkg::COUNT_W'(sws_pkg::DEPTH))
    else $error("full status without full stack");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sws_pkg::STAT_EMPTY |-> count == '0 && data == '0)
    else $error("empty status with entries or data");

endmodule

bind stack_with_search sws_checker u_sws_checker (.*);

`default_nettype wire
